// ===== src/paging_frame_queue_scheduler_macros.svh =====
// ============================================================================
// Paging frame queue scheduler assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef PAGING_FRAME_QUEUE_SCHEDULER_MACROS_SVH
`define PAGING_FRAME_QUEUE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFQS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pfqs_pkg.sv =====
// ============================================================================
// Paging frame queue scheduler package
// Payload types, result codes and configuration constants shared across the design and bench.
// ============================================================================
package pfqs_pkg;

   localparam int UE_W    = 31;
   localparam int FRAME_W = 10;
   localparam int CFG_W   = 4;
   localparam int OFF_W   = 8;

   // Input modes.
   localparam logic MODE_PAGE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_QUEUED  = 2'd0;
   localparam logic [1:0] KIND_DROPPED = 2'd1;
   localparam logic [1:0] KIND_RECORD  = 2'd2;
   localparam logic [1:0] KIND_EMPTY   = 2'd3;

   // Register indexes.
   localparam logic [0:0] CSR_DRX_LOG2 = 1'b0;
   localparam logic [0:0] CSR_PF_LOG2  = 1'b1;

   localparam logic [CFG_W-1:0] DRX_LOG2_MIN   = 4'd5;
   localparam logic [CFG_W-1:0] DRX_LOG2_MAX   = 4'd8;
   localparam logic [CFG_W-1:0] DRX_LOG2_RESET = 4'd5;
   localparam logic [CFG_W-1:0] PF_LOG2_RESET  = 4'd4;

   typedef struct packed {
      logic            mode;
      logic [UE_W-1:0] ue_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] target_frame;
      logic [UE_W-1:0]    paged_ue;
      logic               mib_due;
      logic               last;
   } rsp_payload_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic             mode;
      logic [UE_W-1:0]  ue_id;
      logic [OFF_W-1:0] offset;
   } cmd_type;

   // Effective (saturated) configuration seen by the back end.
   typedef struct packed {
      logic [CFG_W-1:0] drx_log2;
   } cfg_type;

   // Handshake between the command queue and its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/pfqs_chan_if.sv =====
// ============================================================================
// Paging frame queue scheduler channel
// Valid/ready channel carrying one payload item per handshake.
// ============================================================================
interface pfqs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pfqs_front.sv =====
// ============================================================================
// Paging frame queue scheduler front end
// Holds the configuration, accepts items and computes the paging offset.
// ============================================================================
module pfqs_front (
   input  logic                          clock,
   input  logic                          reset,
   pfqs_chan_if.sink                     req_chan,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [pfqs_pkg::CFG_W-1:0]    csr_wdata,
   input  pfqs_pkg::queue_status_type    q_status,
   input  logic                          clear_busy,
   output logic                          q_push,
   output pfqs_pkg::cmd_type             q_cmd,
   output pfqs_pkg::cfg_type             cfg
);

   logic [pfqs_pkg::CFG_W-1:0] drx_ff, drx_in;
   logic [pfqs_pkg::CFG_W-1:0] pf_ff, pf_in;
   logic [pfqs_pkg::CFG_W-1:0] dl;
   logic [pfqs_pkg::CFG_W-1:0] pl;
   logic [pfqs_pkg::CFG_W-1:0] shift;
   logic [pfqs_pkg::OFF_W:0]   n_mask;
   logic [pfqs_pkg::OFF_W-1:0] ue_low;

   always_comb begin
      drx_in = drx_ff;
      pf_in  = pf_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfqs_pkg::CSR_DRX_LOG2: drx_in = csr_wdata;
            pfqs_pkg::CSR_PF_LOG2:  pf_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drx_ff <= pfqs_pkg::DRX_LOG2_RESET;
         pf_ff  <= pfqs_pkg::PF_LOG2_RESET;
      end else begin
         drx_ff <= drx_in;
         pf_ff  <= pf_in;
      end
   end

   // Saturate the cycle length, then clip the paging frame count to it.
   assign dl = (drx_ff < pfqs_pkg::DRX_LOG2_MIN) ? pfqs_pkg::DRX_LOG2_MIN :
               (drx_ff > pfqs_pkg::DRX_LOG2_MAX) ? pfqs_pkg::DRX_LOG2_MAX : drx_ff;
   assign pl = (pf_ff > dl) ? dl : pf_ff;
   assign shift = dl - pl;
   assign cfg.drx_log2 = dl;

   // Offset (T/N) * (id mod N) is a masked low part shifted by log2(T/N).
   assign n_mask = ((pfqs_pkg::OFF_W+1)'(1) << pl) - (pfqs_pkg::OFF_W+1)'(1);
   assign ue_low = req_chan.payload.ue_id[pfqs_pkg::OFF_W-1:0] &
                   n_mask[pfqs_pkg::OFF_W-1:0];

   assign req_chan.ready = !q_status.full && !clear_busy;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      q_cmd.mode   = req_chan.payload.mode;
      q_cmd.ue_id  = req_chan.payload.ue_id;
      q_cmd.offset = (req_chan.payload.mode == pfqs_pkg::MODE_PAGE) ?
                     (ue_low << shift) : '0;
   end

endmodule

// ===== src/pfqs_cmd_queue.sv =====
// ============================================================================
// Paging frame queue scheduler command queue
// Two-entry queue that decouples the front end from the back end.
// ============================================================================
module pfqs_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pfqs_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output pfqs_pkg::cmd_type          head_cmd,
   output pfqs_pkg::queue_status_type status
);

   localparam int QDEPTH = 2;

   pfqs_pkg::cmd_type entry_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == 2'(QDEPTH));
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/pfqs_back.sv =====
// ============================================================================
// Paging frame queue scheduler back end
// Sequencer that probes and fills frame queues and drains them on a tick.
// ============================================================================
module pfqs_back #(
   parameter int FRAMES          = 1024,
   parameter int SLOTS_PER_FRAME = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pfqs_pkg::cfg_type          cfg,
   input  pfqs_pkg::queue_status_type q_status,
   input  pfqs_pkg::cmd_type          q_cmd,
   output logic                       q_pop,
   output logic                       clear_busy,
   pfqs_chan_if.source                rsp_chan
);

   localparam int FW          = $clog2(FRAMES);
   localparam int FILLW       = $clog2(SLOTS_PER_FRAME + 1);
   localparam int SLOTS_TOTAL = FRAMES * SLOTS_PER_FRAME;
   localparam int AW          = $clog2(SLOTS_TOTAL);
   localparam int TW          = pfqs_pkg::OFF_W + 1;

   localparam logic [FW-1:0]    LAST_FRAME = FW'(FRAMES - 1);
   localparam logic [FW:0]      FRAMES_X   = (FW+1)'(FRAMES);
   localparam logic [FILLW-1:0] SLOTS_F    = FILLW'(SLOTS_PER_FRAME);
   localparam logic [AW-1:0]    SLOTS_A    = AW'(SLOTS_PER_FRAME);

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_PG_START = 7'b0000100,
      ST_PG_CHECK = 7'b0001000,
      ST_TK_START = 7'b0010000,
      ST_TK_FILL  = 7'b0100000,
      ST_TK_EMIT  = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [FW-1:0]                frame_ff, frame_in;
   logic [FW-1:0]                clr_ff, clr_in;
   logic [pfqs_pkg::UE_W-1:0]    ue_ff, ue_in;
   logic [pfqs_pkg::OFF_W-1:0]   off_ff, off_in;
   logic [FW-1:0]                q_ff, q_in;
   logic [FW:0]                  k_ff, k_in;
   logic [FILLW-1:0]             cnt_ff, cnt_in;
   logic [FILLW-1:0]             i_ff, i_in;
   logic                         out_valid_ff;
   pfqs_pkg::rsp_payload_type    out_ff;
   logic [FILLW-1:0]             fill_rd_ff;
   logic [pfqs_pkg::UE_W-1:0]    slot_rd_ff;

   logic [FILLW-1:0]             fill_ram [FRAMES];
   logic [pfqs_pkg::UE_W-1:0]    slot_ram [SLOTS_TOTAL];

   logic [TW-1:0]                t_len;
   logic [TW-1:0]                t_m1;
   logic [FW:0]                  cands;
   logic [pfqs_pkg::OFF_W-1:0]   phase;
   logic [TW-1:0]                delta;
   logic [FW:0]                  q0_sum;
   logic [FW-1:0]                q0;
   logic [FW:0]                  qn_sum;
   logic [FW-1:0]                qn;
   logic                         slot_free;
   logic                         fill_ok;
   logic                         k_last;
   logic                         i_last;
   logic [FW-1:0]                frame_next;
   logic                         fill_we;
   logic [FW-1:0]                fill_waddr;
   logic [FW-1:0]                fill_raddr;
   logic [FILLW-1:0]             fill_wdata;
   logic                         slot_we;
   logic [AW-1:0]                slot_waddr;
   logic [AW-1:0]                slot_raddr;
   logic                         i_adv;
   logic                         emit;
   pfqs_pkg::rsp_payload_type    emit_data;

   assign t_len  = TW'(1) << cfg.drx_log2;
   assign t_m1   = t_len - TW'(1);
   assign cands  = FRAMES_X >> cfg.drx_log2;
   assign phase  = frame_ff[pfqs_pkg::OFF_W-1:0] & t_m1[pfqs_pkg::OFF_W-1:0];
   assign delta  = (off_ff > phase) ? ({1'b0, off_ff} - {1'b0, phase}) :
                   (t_len + {1'b0, off_ff} - {1'b0, phase});
   assign q0_sum = {1'b0, frame_ff} + (FW+1)'(delta);
   assign q0     = (q0_sum >= FRAMES_X) ? FW'(q0_sum - FRAMES_X) : FW'(q0_sum);
   assign qn_sum = {1'b0, q_ff} + (FW+1)'(t_len);
   assign qn     = (qn_sum >= FRAMES_X) ? FW'(qn_sum - FRAMES_X) : FW'(qn_sum);

   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign fill_ok    = (fill_rd_ff < SLOTS_F);
   assign k_last     = ((k_ff + (FW+1)'(1)) == cands);
   assign i_last     = ((i_ff + FILLW'(1)) == cnt_ff);
   assign frame_next = (frame_ff == LAST_FRAME) ? '0 : frame_ff + FW'(1);
   assign clear_busy = (state_ff == ST_CLEAR);

   assign slot_waddr = AW'(q_ff) * SLOTS_A + AW'(fill_rd_ff);
   assign slot_raddr = AW'(frame_ff) * SLOTS_A +
                       AW'(i_adv ? (i_ff + FILLW'(1)) : i_ff);

   always_comb begin
      state_in   = state_ff;
      frame_in   = frame_ff;
      clr_in     = clr_ff;
      ue_in      = ue_ff;
      off_in     = off_ff;
      q_in       = q_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      i_in       = i_ff;
      q_pop      = 1'b0;
      fill_we    = 1'b0;
      fill_waddr = q_ff;
      fill_wdata = fill_rd_ff + FILLW'(1);
      fill_raddr = q_ff;
      slot_we    = 1'b0;
      i_adv      = 1'b0;
      emit       = 1'b0;

      emit_data.kind         = pfqs_pkg::KIND_QUEUED;
      emit_data.frame        = pfqs_pkg::FRAME_W'(frame_ff);
      emit_data.target_frame = pfqs_pkg::FRAME_W'(q_ff);
      emit_data.paged_ue     = ue_ff;
      emit_data.mib_due      = 1'b0;
      emit_data.last         = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + FW'(1);
            if (clr_ff == LAST_FRAME) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               ue_in    = q_cmd.ue_id;
               off_in   = q_cmd.offset;
               k_in     = '0;
               i_in     = '0;
               state_in = (q_cmd.mode == pfqs_pkg::MODE_TICK) ? ST_TK_START :
                                                                ST_PG_START;
            end
         end
         ST_PG_START: begin
            fill_raddr = q0;
            q_in       = q0;
            state_in   = ST_PG_CHECK;
         end
         ST_PG_CHECK: begin
            if (fill_ok) begin
               if (slot_free) begin
                  fill_we  = 1'b1;
                  slot_we  = 1'b1;
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (k_last) begin
               emit_data.kind         = pfqs_pkg::KIND_DROPPED;
               emit_data.target_frame = '0;
               if (slot_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               fill_raddr = qn;
               q_in       = qn;
               k_in       = k_ff + (FW+1)'(1);
            end
         end
         ST_TK_START: begin
            fill_raddr = frame_ff;
            state_in   = ST_TK_FILL;
         end
         ST_TK_FILL: begin
            fill_raddr             = frame_ff;
            cnt_in                 = fill_rd_ff;
            emit_data.kind         = pfqs_pkg::KIND_EMPTY;
            emit_data.target_frame = pfqs_pkg::FRAME_W'(frame_ff);
            emit_data.paged_ue     = '0;
            emit_data.mib_due      = (frame_ff[2:0] == 3'd0);
            if (fill_rd_ff == '0) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  frame_in = frame_next;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_TK_EMIT;
            end
         end
         ST_TK_EMIT: begin
            fill_raddr             = frame_ff;
            emit_data.kind         = pfqs_pkg::KIND_RECORD;
            emit_data.target_frame = pfqs_pkg::FRAME_W'(frame_ff);
            emit_data.paged_ue     = slot_rd_ff;
            emit_data.mib_due      = (frame_ff[2:0] == 3'd0);
            emit_data.last         = i_last;
            if (slot_free) begin
               emit = 1'b1;
               if (i_last) begin
                  fill_we    = 1'b1;
                  fill_waddr = frame_ff;
                  fill_wdata = '0;
                  frame_in   = frame_next;
                  state_in   = ST_IDLE;
               end else begin
                  i_adv = 1'b1;
                  i_in  = i_ff + FILLW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         frame_ff     <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         clr_ff   <= clr_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ue_ff  <= ue_in;
      off_ff <= off_in;
      q_ff   <= q_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      i_ff   <= i_in;
      if (emit) begin
         out_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_ram[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_ram[fill_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ram[slot_waddr] <= ue_ff;
      end
      slot_rd_ff <= slot_ram[slot_raddr];
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

// ===== src/paging_frame_queue_scheduler.sv =====
// ============================================================================
// Paging frame queue scheduler
// Per-frame paging queues fed by page requests and drained by frame ticks.
//
// The block keeps FRAMES paging queues of up to SLOTS_PER_FRAME UE
// identities each and a running system frame number. A page request computes
// the UE's paging frame offset from the DRX configuration and is placed in
// the first frame after the current one that matches that offset, trying
// later DRX periods when a queue is full; it yields exactly one result item,
// queued or dropped. A frame tick drains the current frame's queue as one
// record item per UE (or one empty-frame item), flags a MIB on frames that
// are a multiple of eight and advances the frame number. Items are handled
// one at a time by the back-end sequencer, while a two-entry command queue
// and an output register let the input and output sides stall independently.
// A page request probes P candidate frames (1 to FRAMES/T, one probe per
// cycle through the single read port of the fill-count memory); a tick
// reads R records, one per cycle through the slot memory read port while
// the output does not stall. After reset the fill counts are cleared in a
// pass over all frames during which no item is accepted; configuration
// writes are taken at any time but must only be issued while the block is
// idle.
// ============================================================================
`include "paging_frame_queue_scheduler_macros.svh"

module paging_frame_queue_scheduler #(
   parameter int FRAMES          = 1024,
   parameter int SLOTS_PER_FRAME = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   pfqs_chan_if.sink                  req_chan,
   pfqs_chan_if.source                rsp_chan,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [pfqs_pkg::CFG_W-1:0] csr_wdata
);

   // Effective configuration, saturated by the front end.
   pfqs_pkg::cfg_type          cfg;

   // Command path between the front end, the queue and the back end.
   pfqs_pkg::cmd_type          push_cmd;
   pfqs_pkg::cmd_type          head_cmd;
   pfqs_pkg::queue_status_type q_status;
   logic                       q_push;
   logic                       q_pop;

   // High while the back end clears the fill counts after reset.
   logic                       clear_busy;

   // The front end accepts items, holds the registers and computes the
   // paging frame offset of each page request.
   pfqs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .clear_busy (clear_busy),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .cfg        (cfg)
   );

   // The queue lets a new item be taken while the back end is still busy.
   pfqs_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // The back end owns the frame number and both memories and produces all
   // result items through its output register.
   pfqs_back #(
      .FRAMES          (FRAMES),
      .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_status   (q_status),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

   // A dropped page always closes its item and names no target frame.
   `PFQS_ASSERT_IMPL(a_drop_format, rsp_chan.valid && rsp_chan.payload.kind == pfqs_pkg::KIND_DROPPED, rsp_chan.payload.last && rsp_chan.payload.target_frame == '0, "dropped page item malformed")

   // Tick items always refer to the frame being drained.
   `PFQS_ASSERT_IMPL(a_tick_target, rsp_chan.valid && (rsp_chan.payload.kind == pfqs_pkg::KIND_RECORD || rsp_chan.payload.kind == pfqs_pkg::KIND_EMPTY), rsp_chan.payload.target_frame == rsp_chan.payload.frame, "tick item target differs from frame")

   // Page results are single items and never carry a MIB flag.
   `PFQS_ASSERT_IMPL(a_page_single, rsp_chan.valid && (rsp_chan.payload.kind == pfqs_pkg::KIND_QUEUED || rsp_chan.payload.kind == pfqs_pkg::KIND_DROPPED), rsp_chan.payload.last && !rsp_chan.payload.mib_due, "page item not single or flags MIB")

   // The back end never pops two commands in a row.
   `PFQS_ASSERT_NEXT(a_single_pop, q_pop, !q_pop, "back end took two commands in a row")

endmodule

// ===== bench/pfqs_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Paging frame queue scheduler checker
// Watches the request, result and register ports, keeps its own copy of the
// frame queues, and compares every accepted result with the oldest prediction.
// ============================================================================
module pfqs_checker import pfqs_pkg::*; #(
   parameter int FRAMES          = 1024,
   parameter int SLOTS_PER_FRAME = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    due_count
);

   logic [CFG_W-1:0] drx_cfg;
   logic [CFG_W-1:0] pf_cfg;
   int               frame_now;
   int               fill [FRAMES];
   logic [UE_W-1:0]  slots [FRAMES][SLOTS_PER_FRAME];
   rsp_payload_type  due_results [$];
   int               fails = 0;

   // A page request lands in the first candidate frame with room, one DRX
   // cycle apart, or is dropped when every candidate is full.
   function automatic void schedule_page(input logic [UE_W-1:0] ue);
      int dl, pl, t, off, phase, delta, cands, q;
      rsp_payload_type r;
      dl = int'(drx_cfg);
      if (dl < int'(DRX_LOG2_MIN)) dl = int'(DRX_LOG2_MIN);
      if (dl > int'(DRX_LOG2_MAX)) dl = int'(DRX_LOG2_MAX);
      pl = int'(pf_cfg);
      if (pl > dl) pl = dl;
      t = 1 << dl;
      off = (t >> pl) * (int'(ue[9:0]) & ((1 << pl) - 1));
      phase = frame_now & (t - 1);
      delta = (off > phase) ? off - phase : t + off - phase;
      cands = FRAMES / t;
      if (cands == 0) cands = 1;
      r.kind         = KIND_DROPPED;
      r.frame        = FRAME_W'(frame_now);
      r.target_frame = '0;
      r.paged_ue     = ue;
      r.mib_due      = 1'b0;
      r.last         = 1'b1;
      for (int k = 0; k < cands; k++) begin
         q = (frame_now + delta + k * t) % FRAMES;
         if (fill[q] < SLOTS_PER_FRAME) begin
            slots[q][fill[q]] = ue;
            fill[q]++;
            r.kind         = KIND_QUEUED;
            r.target_frame = FRAME_W'(q);
            break;
         end
      end
      due_results.push_back(r);
   endfunction

   // A tick empties the current frame's queue and moves to the next frame.
   function automatic void drain_frame();
      int f, cnt;
      rsp_payload_type r;
      f = frame_now;
      cnt = fill[f];
      r.kind         = KIND_EMPTY;
      r.frame        = FRAME_W'(f);
      r.target_frame = FRAME_W'(f);
      r.paged_ue     = '0;
      r.mib_due      = (f % 8) == 0;
      r.last         = 1'b1;
      if (cnt == 0) begin
         due_results.push_back(r);
      end else begin
         for (int i = 0; i < cnt; i++) begin
            r.kind     = KIND_RECORD;
            r.paged_ue = slots[f][i];
            r.last     = (i == cnt - 1);
            due_results.push_back(r);
         end
      end
      fill[f] = 0;
      frame_now = (f + 1) % FRAMES;
   endfunction

   function automatic void flag_failure(input string what, input rsp_payload_type want,
                                        input rsp_payload_type got);
      fails++;
      if (fails <= 10)
         $display("%0t: %s: expected kind=%0d frame=%0d target=%0d ue=%h mib=%0d last=%0d,",
                  $realtime, what, want.kind, want.frame, want.target_frame, want.paged_ue,
                  want.mib_due, want.last,
                  " got kind=%0d frame=%0d target=%0d ue=%h mib=%0d last=%0d",
                  got.kind, got.frame, got.target_frame, got.paged_ue, got.mib_due,
                  got.last);
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         drx_cfg   = DRX_LOG2_RESET;
         pf_cfg    = PF_LOG2_RESET;
         frame_now = 0;
         foreach (fill[i]) fill[i] = 0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DRX_LOG2: drx_cfg = csr_wdata;
               CSR_PF_LOG2:  pf_cfg  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_payload.mode == MODE_TICK)
               drain_frame();
            else
               schedule_page(req_payload.ue_id);
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               flag_failure("result with nothing outstanding", '0, rsp_payload);
            end else begin
               want = due_results.pop_front();
               if (rsp_payload.kind !== want.kind || rsp_payload.frame !== want.frame ||
                   rsp_payload.target_frame !== want.target_frame ||
                   rsp_payload.paged_ue !== want.paged_ue ||
                   rsp_payload.mib_due !== want.mib_due || rsp_payload.last !== want.last)
                  flag_failure("result mismatch", want, rsp_payload);
            end
         end
      end
      due_count  <= due_results.size();
      fail_count <= fails;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Paging frame queue scheduler testbench
// Drives page requests and frame ticks through the request channel under
// several register settings and idle patterns; a checker beside the block
// predicts and compares every result item.
// ============================================================================
module tb;
   import pfqs_pkg::*;

   localparam int FRAMES          = 1024;
   localparam int SLOTS_PER_FRAME = 32;

   // Idle patterns applied to the two sides of the block.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [0:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int               send_gap_pct = 0;
   int               stall_pct = 0;
   int               fail_count;
   int               due_count;
   int               ticks_sent = 0;
   logic [4:0]       next_off;
   logic [UE_W-1:0]  full_ue;

   pfqs_chan_if #(.payload_type(req_payload_type)) req_chan ();
   pfqs_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   paging_frame_queue_scheduler #(
      .FRAMES          (FRAMES),
      .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pfqs_checker #(
      .FRAMES          (FRAMES),
      .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
   ) page_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .due_count   (due_count)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random, redrawn every cycle, so that stalls fall
   // on every phase of a multi-record drain.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic set_idle(input idle_mode_type mode);
      send_gap_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 37 : 0;
      stall_pct    = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 37 : 0;
   endtask

   // Offers one item, after a random gap, and returns at the edge where it was
   // taken. The valid stays high on return so that back-to-back items flow
   // without a bubble. Ticks are counted to know the current frame number.
   task automatic send_item(input logic mode, input logic [UE_W-1:0] ue);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.payload.mode  <= mode;
      req_chan.payload.ue_id <= ue;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (mode == MODE_TICK) ticks_sent++;
   endtask

   // Holds the sender off until every predicted result has come back. The
   // first edge lets the checker count the item taken at the current edge.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   // Both registers, one write per cycle; only issued while the block is idle.
   task automatic set_config(input logic [CFG_W-1:0] drx, input logic [CFG_W-1:0] pf);
      csr_we    <= 1'b1;
      csr_index <= CSR_DRX_LOG2;
      csr_wdata <= drx;
      @(posedge clock);
      csr_index <= CSR_PF_LOG2;
      csr_wdata <= pf;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Half of the identities share a few low bits, so that many of them map to
   // the same paging frame.
   function automatic logic [UE_W-1:0] random_ue();
      logic [UE_W-1:0] v;
      v = UE_W'($urandom);
      if ($urandom_range(1) == 1) v[9:0] = 10'($urandom_range(3));
      return v;
   endfunction

   // Register settings of the random phases: in range, below and above range
   // for the DRX length, and paging frame counts both clipped and unclipped.
   localparam logic [CFG_W-1:0] DRX_STEPS [8] = '{4'd5, 4'd8, 4'd0, 4'd15, 4'd6, 4'd7, 4'd4, 4'd9};
   localparam logic [CFG_W-1:0] PF_STEPS  [8] = '{4'd4, 4'd0, 4'd15, 4'd9, 4'd2, 4'd8, 4'd3, 4'd0};

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_DRX_LOG2;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset settings: a DRX cycle of 32 frames with 16
      // paging frames, so the offset is twice the low four identity bits.
      // The block is busy clearing its fill counts for a while; the first
      // item simply waits for ready.
      set_idle(IDLE_NONE);
      send_item(MODE_TICK, '0);              // empty frame 0, MIB frame
      send_item(MODE_PAGE, '0);              // offset 0 behind phase 1
      send_item(MODE_PAGE, 31'h7FFF_FFFF);   // largest identity, offset 30
      send_item(MODE_PAGE, 31'd1);           // offset 2, just ahead
      send_item(MODE_PAGE, 31'd1025);        // same frame once the id wraps at 1024
      send_item(MODE_PAGE, 31'h2AAA_AAAA);
      send_item(MODE_PAGE, 31'h5555_5555);
      send_item(MODE_TICK, '0);              // empty frame 1, no MIB
      send_item(MODE_PAGE, 31'd1);           // offset equals phase: a full cycle ahead
      send_item(MODE_TICK, '0);              // frame 2 drains two records
      // Let everything drain before going on.
      wait_idle();
      repeat (9) send_item(MODE_TICK, '0);   // through MIB frame 8 and a record at 10

      // Random phases, each under new register settings and its own idle
      // pattern. Registers change only with nothing outstanding.
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         set_config(DRX_STEPS[p], PF_STEPS[p]);
         set_idle(idle_mode_type'(p % 4));
         for (int i = 0; i < 7; i++) begin
            if ($urandom_range(99) < 30)
               send_item(MODE_TICK, UE_W'($urandom));
            else
               send_item(MODE_PAGE, random_ue());
         end
      end

      // Shortest cycle with one paging frame per frame: the offset is the low
      // five identity bits, chosen so that every request targets the next
      // frame. Thirty-two of them fill that queue, the last one moves on to
      // the following DRX cycle, and the second tick drains 32 records.
      wait_idle();
      set_config(4'd5, 4'd5);
      set_idle(IDLE_BOTH);
      next_off = 5'(ticks_sent + 1);
      repeat (33) begin
         full_ue      = random_ue();
         full_ue[4:0] = next_off;
         send_item(MODE_PAGE, full_ue);
      end
      repeat (2) send_item(MODE_TICK, '0);

      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && due_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/pfqs_pkg.sv
src/pfqs_chan_if.sv
src/pfqs_front.sv
src/pfqs_cmd_queue.sv
src/pfqs_back.sv
src/paging_frame_queue_scheduler.sv
bench/pfqs_checker.sv
bench/tb.sv
